// File: hw/rtl/cia_pkg.sv
`default_nettype none

package cia_pkg;

    // Sizing
    localparam int ID_COUNT    = 256;
    localparam int HANDLE_BITS = 64;
    localparam int ID_W        = $clog2(ID_COUNT);
    localparam int CNT_W       = ID_W + 1;
    localparam int LIMIT_W     = 9;
    localparam int HANDLE_PW   = 64;

    // Request codes
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_TAKE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Response codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [1:0]           action;
        logic [HANDLE_PW-1:0] handle_in;
        logic [7:0]           id_in;
        logic                 removal_allowed;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [7:0]           id_out;
        logic [HANDLE_PW-1:0] handle_out;
        logic                 is_empty;
    } t_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/cyclic_id_allocator.sv
`default_nettype none

// Cyclic identifier allocator.
// Request channel (i_in_valid / o_in_stall / i_in_data) carries one transaction
// per request: allocate, take and remove, query empty, or clear all. Response
// channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
// transaction per request, in order. i_cfg_we / i_cfg_data write the id limit
// while the block is idle; 0 or a value above the id count means the full count.
// Path from the accepting edge to the edge that loads the response register:
//   query, clear: DONE; take: TAKE, TRESP, DONE (registered handle memory read);
//   allocate: SCAN, then DONE, with k = 1..limit entries probed by the scan unit,
//   which tests one occupancy bit per cycle starting at the search pointer
//   and wrapping at the limit. A full map costs limit probes.
// The sequencer goes idle on the edge that loads the output register.
// A new request is taken only when the sequencer is idle; a finished response
// sits in the output register, so the next request may start while the
// receiver stalls. A response that is ready while the output register is
// still held waits in the sequencer until the register drains.
// Reset (synchronous, active low) frees all identifiers, zeroes the search
// pointer, restores the limit to the full count and empties the output.
module cyclic_id_allocator (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire cia_pkg::t_req               i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output cia_pkg::t_rsp                    o_out_data,
    input  wire logic                        i_cfg_we,
    input  wire logic [cia_pkg::LIMIT_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_TAKE  = 3'd2;
    localparam logic [2:0] S_TRESP = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int IW = cia_pkg::ID_W;
    localparam int CW = cia_pkg::CNT_W;
    localparam int HB = cia_pkg::HANDLE_BITS;

    // Control state
    logic [2:0]                    r_state, n_state;
    logic [cia_pkg::ID_COUNT-1:0]  r_occ, n_occ;
    logic [CW-1:0]                 r_count, n_count;
    logic [IW-1:0]                 r_start, n_start;
    logic [cia_pkg::LIMIT_W-1:0]   r_id_limit;
    logic                          r_ov, n_ov;

    // Working registers
    logic [CW-1:0]                 r_lim, n_lim;
    logic [IW-1:0]                 r_ptr, n_ptr;
    logic [CW-1:0]                 r_left, n_left;
    logic [IW-1:0]                 r_id, n_id;
    logic [HB-1:0]                 r_handle, n_handle;
    cia_pkg::t_rsp                 r_res, n_res;
    cia_pkg::t_rsp                 r_out, n_out;

    // Handle store
    logic [HB-1:0]                 r_mem [cia_pkg::ID_COUNT];
    logic [HB-1:0]                 r_rd;
    logic                          mem_we;

    logic [CW-1:0]                 eff_lim;
    logic [CW-1:0]                 ptr_inc;
    logic [IW-1:0]                 ptr_next;
    logic                          out_free;
    logic                          in_acc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_ov || !i_out_stall;

    // Limit of 0 or above the count means the full count
    always_comb begin
        if ((r_id_limit == '0) || (CW'(r_id_limit) > CW'(cia_pkg::ID_COUNT))) begin
            eff_lim = CW'(cia_pkg::ID_COUNT);
        end else begin
            eff_lim = CW'(r_id_limit);
        end
    end

    // Shared scan step: next position, wrapping at the limit
    assign ptr_inc  = {1'b0, r_ptr} + CW'(1);
    assign ptr_next = (ptr_inc == r_lim) ? '0 : ptr_inc[IW-1:0];

    always_comb begin
        n_state  = r_state;
        n_occ    = r_occ;
        n_count  = r_count;
        n_start  = r_start;
        n_lim    = r_lim;
        n_ptr    = r_ptr;
        n_left   = r_left;
        n_id     = r_id;
        n_handle = r_handle;
        n_res    = r_res;
        n_out    = r_out;
        n_ov     = r_ov;
        mem_we   = 1'b0;

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_id     = i_in_data.id_in[IW-1:0];
                    n_handle = i_in_data.handle_in[HB-1:0];
                    n_res    = '0;
                    unique case (i_in_data.action)
                        cia_pkg::ACT_ALLOC: begin
                            n_lim   = eff_lim;
                            n_ptr   = ({1'b0, r_start} < eff_lim) ? r_start : '0;
                            n_left  = eff_lim;
                            n_state = S_SCAN;
                        end
                        cia_pkg::ACT_TAKE: begin
                            if (r_occ[i_in_data.id_in[IW-1:0]] &&
                                i_in_data.removal_allowed) begin
                                n_state = S_TAKE;
                            end else begin
                                n_res.status   = cia_pkg::ST_ABSENT;
                                n_res.is_empty = (r_count == '0);
                                n_state        = S_DONE;
                            end
                        end
                        cia_pkg::ACT_QUERY: begin
                            n_res.status   = cia_pkg::ST_OK;
                            n_res.is_empty = (r_count == '0);
                            n_state        = S_DONE;
                        end
                        cia_pkg::ACT_CLEAR: begin
                            n_occ          = '0;
                            n_count        = '0;
                            n_res.status   = cia_pkg::ST_OK;
                            n_res.is_empty = 1'b1;
                            n_state        = S_DONE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_occ[r_ptr]) begin
                    n_occ[r_ptr]   = 1'b1;
                    mem_we         = 1'b1;
                    n_count        = r_count + CW'(1);
                    n_start        = ptr_next;
                    n_res.status   = cia_pkg::ST_OK;
                    n_res.id_out   = 8'(r_ptr);
                    n_res.is_empty = 1'b0;
                    n_state        = S_DONE;
                end else if (r_left == CW'(1)) begin
                    n_res.status   = cia_pkg::ST_FULL;
                    n_res.is_empty = (r_count == '0);
                    n_state        = S_DONE;
                end else begin
                    n_ptr  = ptr_next;
                    n_left = r_left - CW'(1);
                end
            end
            S_TAKE: begin
                // memory read issued this cycle
                n_occ[r_id] = 1'b0;
                n_count     = r_count - CW'(1);
                n_state     = S_TRESP;
            end
            S_TRESP: begin
                n_res.status     = cia_pkg::ST_OK;
                n_res.handle_out = cia_pkg::HANDLE_PW'(r_rd);
                n_res.is_empty   = (r_count == '0);
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_occ      <= '0;
            r_count    <= '0;
            r_start    <= '0;
            r_ov       <= 1'b0;
            r_id_limit <= cia_pkg::LIMIT_W'(cia_pkg::ID_COUNT);
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_count <= n_count;
            r_start <= n_start;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_id_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_ptr    <= n_ptr;
        r_left   <= n_left;
        r_id     <= n_id;
        r_handle <= n_handle;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // Handle store: one write port (scan hit), one registered read port (take)
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_ptr] <= r_handle;
        end
        if (r_state == S_TAKE) begin
            r_rd <= r_mem[r_id];
        end
    end

    // Occupancy count tracks the map
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_occ)))
        else $error("occupancy count out of step with map");

    // Scan stays inside the latched limit
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (({1'b0, r_ptr} < r_lim) && (r_left != '0)
                                 && (r_left <= r_lim)))
        else $error("scan pointer or step count out of range");

    // A take only reaches the read when the entry is occupied
    a_take_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |-> r_occ[r_id])
        else $error("take of a free entry");

    // Take frees the entry by the response cycle
    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAKE) |=> (r_state == S_TRESP) && !r_occ[$past(r_id)])
        else $error("take did not free its entry");

endmodule

`default_nettype wire
